@@ sv/ewpd_pkg.sv @@
// ----------------------------------------------------------------------------
// ewpd_pkg - shared types and constants of the worker pool dispatcher
// Slot, count and size widths, command codes, register indexes and the
// control bundle of the min/sum scan unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ewpd_pkg;

  // Pool geometry
  localparam int MaxWorkers = 8;
  localparam int SlotBits   = $clog2(MaxWorkers);
  localparam int SizeBits   = $clog2(MaxWorkers + 1);
  localparam int CountBits  = 16;
  localparam int SumBits    = CountBits + SlotBits;
  localparam int ProdBits   = CountBits + SizeBits;
  localparam int MaxwBits   = 4;

  // Stream and config port widths
  localparam int InDataBits  = 8;
  localparam int OutDataBits = 24;
  localparam int CfgAddrBits = 1;
  localparam int CfgDataBits = 16;

  // Register reset values
  localparam logic [CountBits-1:0] SpwReset  = CountBits'(1024);
  localparam logic [MaxwBits-1:0]  MaxwReset = MaxwBits'(8);

  typedef enum logic [1:0] {
    CMD_NEW   = 2'd0,
    CMD_IDLE  = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [CfgAddrBits-1:0] {
    CFG_SPW  = 1'b0,
    CFG_MAXW = 1'b1
  } cfg_idx_e;

  // Scan unit control
  typedef struct packed {
    logic clr;
    logic step;
    logic sum_en;
  } scan_ctl_t;

  // Clamp the max_workers register to 1..MaxWorkers
  function automatic logic [SizeBits-1:0] clamp_max(input logic [MaxwBits-1:0] m);
    logic [SizeBits-1:0] r;
    if (m == '0) begin
      r = SizeBits'(1);
    end else if (32'(m) > MaxWorkers) begin
      r = SizeBits'(MaxWorkers);
    end else begin
      r = SizeBits'(m);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/ewpd_div.sv @@
// ----------------------------------------------------------------------------
// ewpd_div - iterative restoring divider
// Divides the per-worker session limit by the clamped pool limit, one
// quotient bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ewpd_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [ewpd_pkg::CountBits-1:0] dividend_i,
  input  wire logic [ewpd_pkg::SizeBits-1:0]  divisor_i,
  output logic                               busy_o,
  output logic [ewpd_pkg::CountBits-1:0]      quot_o
);
  import ewpd_pkg::*;

  localparam int CntBits = $clog2(CountBits + 1);

  logic [CountBits-1:0] num_q;
  logic [SizeBits-1:0]  rem_q;
  logic [SizeBits-1:0]  dsr_q;
  logic [CntBits-1:0]   cnt_q;
  logic [SizeBits:0]    rem_sh;
  logic                 fits;

  // Trial subtract of the shifted remainder
  assign rem_sh = {rem_q, num_q[CountBits-1]};
  assign fits   = rem_sh >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      num_q <= '0;
      rem_q <= '0;
      dsr_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntBits'(CountBits);
      num_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CntBits'(1);
      num_q <= {num_q[CountBits-2:0], fits};
      if (fits) begin
        rem_q <= SizeBits'(rem_sh - {1'b0, dsr_q});
      end else begin
        rem_q <= rem_sh[SizeBits-1:0];
      end
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = num_q;

endmodule

`default_nettype wire

@@ sv/ewpd_scan.sv @@
// ----------------------------------------------------------------------------
// ewpd_scan - shared minimum and sum unit
// Takes one load value per step, keeps the last minimum with its pool
// position and slot, and optionally accumulates the total load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ewpd_scan (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ewpd_pkg::scan_ctl_t           ctl_i,
  input  wire logic [ewpd_pkg::CountBits-1:0] val_i,
  input  wire logic [ewpd_pkg::SlotBits-1:0]  pos_i,
  input  wire logic [ewpd_pkg::SlotBits-1:0]  slot_i,
  output logic [ewpd_pkg::CountBits-1:0]      min_o,
  output logic [ewpd_pkg::SlotBits-1:0]       pos_o,
  output logic [ewpd_pkg::SlotBits-1:0]       slot_o,
  output logic [ewpd_pkg::SumBits-1:0]        sum_o
);
  import ewpd_pkg::*;

  logic                 have_q;
  logic [CountBits-1:0] min_q;
  logic [SlotBits-1:0]  pos_q;
  logic [SlotBits-1:0]  slot_q;
  logic [SumBits-1:0]   sum_q;

  // Take the new value on ties so the last minimum wins
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      min_q  <= '0;
      pos_q  <= '0;
      slot_q <= '0;
      sum_q  <= '0;
    end else if (ctl_i.clr) begin
      have_q <= 1'b0;
      min_q  <= '0;
      pos_q  <= '0;
      slot_q <= '0;
      sum_q  <= '0;
    end else if (ctl_i.step) begin
      if (!have_q || val_i <= min_q) begin
        have_q <= 1'b1;
        min_q  <= val_i;
        pos_q  <= pos_i;
        slot_q <= slot_i;
      end
      if (ctl_i.sum_en) begin
        sum_q <= sum_q + SumBits'(val_i);
      end
    end
  end

  assign min_o  = min_q;
  assign pos_o  = pos_q;
  assign slot_o = slot_q;
  assign sum_o  = sum_q;

endmodule

`default_nettype wire

@@ sv/elastic_worker_pool_dispatcher.sv @@
// ----------------------------------------------------------------------------
// elastic_worker_pool_dispatcher - session placement on a growable pool
// Sequencer, pool state and result register around a shared min/sum
// scan unit and an iterative divider.
// ----------------------------------------------------------------------------
// Usage:
//   The s_axis channel carries one command per beat: tuser is the command
//   (new session, idle tick, session closed), tdata the closing slot. Each
//   command yields exactly one m_axis beat with the placement, growth,
//   retirement and drain status and the pool size after the command.
//   The cfg channel writes sessions_per_worker (index 0) and max_workers
//   (index 1); always ready; write only while the block idles (not enforced).
// Timing:
//   A close or an unknown command goes through ST_CLOSE, which raises
//   m_axis_tvalid_o once the output register is free. A new session or idle
//   tick scans the N pool entries twice through the shared compare/add unit
//   (plus a search of up to N entries for a retiring worker), while the
//   16-step divider runs alongside; the result is registered in ST_DECIDE once
//   the divider is done and the output register is free. The block takes one
//   command at a time; s_axis_tready_o is high only between commands.
// Reset and stall:
//   Reset leaves one worker on slot 0, all counts zero, no drain mark and
//   the register defaults. A finished result waits in the output register;
//   the next command is accepted meanwhile but its result is held until the
//   receiver takes the pending beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module elastic_worker_pool_dispatcher (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // closing_worker [2:0], zero padded
  input  wire logic [ewpd_pkg::InDataBits-1:0]  s_axis_tdata_i,
  // cmd [1:0]
  input  wire logic [1:0]                       s_axis_tuser_i,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // assigned_valid [0], assigned_worker [3:1], added_valid [4],
  // added_worker [7:5], retired_valid [8], retired_worker [11:9],
  // draining_valid [12], draining_worker [15:13], worker_total [19:16]
  output logic [ewpd_pkg::OutDataBits-1:0]      m_axis_tdata_o,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [ewpd_pkg::CfgAddrBits-1:0] cfg_addr_i,
  input  wire logic [ewpd_pkg::CfgDataBits-1:0] cfg_data_i
);
  import ewpd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_RETIRE,
    ST_SCAN1,
    ST_MID,
    ST_SCAN2,
    ST_DECIDE
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [CountBits-1:0] spw_q;
  logic [MaxwBits-1:0]  maxw_q;

  // Pool state
  logic [SlotBits-1:0]  order_q [MaxWorkers];
  logic [CountBits-1:0] load_q  [MaxWorkers];
  logic [SizeBits-1:0]  size_q;
  logic [MaxWorkers-1:0] used_q;
  logic                 mark_q;
  logic [SlotBits-1:0]  drain_q;

  // Per-command working registers
  cmd_e                 cmd_q;
  logic [SlotBits-1:0]  cw_q;
  logic [SlotBits-1:0]  idx_q;
  logic                 ret_v_q;
  logic [SlotBits-1:0]  ret_w_q;
  logic [CountBits-1:0] min1_v_q;
  logic [SlotBits-1:0]  min1_p_q;
  logic [SlotBits-1:0]  min1_s_q;
  logic [SumBits-1:0]   sum_q;

  // Output register
  logic                   m_valid_q;
  logic [OutDataBits-1:0] m_data_q;

  // Internal nets
  logic                 in_fire;
  logic                 out_free;
  logic                 res_load;
  logic                 idx_last;
  logic [SlotBits-1:0]  rd_addr;
  logic [CountBits-1:0] rd_data;
  logic [SlotBits-1:0]  cur_slot;
  scan_ctl_t            scan_ctl;
  logic [CountBits-1:0] sec_v;
  logic [SlotBits-1:0]  sec_p;
  logic [SlotBits-1:0]  sec_s;
  logic [SumBits-1:0]   scan_sum;
  logic                 div_busy;
  logic [CountBits-1:0] quot;
  logic [SizeBits-1:0]  mx;
  logic [SlotBits-1:0]  free_slot;
  logic [CountBits:0]   min_inc;
  logic [CountBits:0]   sec_inc;
  logic                 grow_ok;
  logic [ProdBits-1:0]  prod;
  logic                 low_load;
  logic                 is_new;
  cmd_e                 in_cmd;

  assign in_cmd          = cmd_e'(s_axis_tuser_i);
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign res_load        = ((state_q == ST_CLOSE) || ((state_q == ST_DECIDE) && !div_busy))
                           && out_free;
  assign cfg_ready_o     = 1'b1;
  assign idx_last        = ({1'b0, idx_q} == size_q - SizeBits'(1));
  assign is_new          = (cmd_q == CMD_NEW);
  assign mx              = clamp_max(maxw_q);

  // Single read port into the load counters
  always_comb begin
    case (state_q)
      ST_IDLE:  rd_addr = drain_q;
      ST_CLOSE: rd_addr = cw_q;
      default:  rd_addr = order_q[idx_q];
    endcase
  end
  assign rd_data  = load_q[rd_addr];
  assign cur_slot = order_q[idx_q];

  // Scan unit control
  always_comb begin
    scan_ctl.clr    = in_fire || (state_q == ST_MID);
    scan_ctl.step   = (state_q == ST_SCAN1) || ((state_q == ST_SCAN2) && (idx_q != min1_p_q));
    scan_ctl.sum_en = (state_q == ST_SCAN1);
  end

  ewpd_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (scan_ctl),
    .val_i  (rd_data),
    .pos_i  (idx_q),
    .slot_i (cur_slot),
    .min_o  (sec_v),
    .pos_o  (sec_p),
    .slot_o (sec_s),
    .sum_o  (scan_sum)
  );

  ewpd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_fire),
    .dividend_i (spw_q),
    .divisor_i  (mx),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // Lowest slot not in the pool
  always_comb begin
    free_slot = '0;
    for (int i = MaxWorkers - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_slot = SlotBits'(i);
      end
    end
  end

  // Decision terms
  assign min_inc  = {1'b0, min1_v_q} + (CountBits+1)'(1);
  assign sec_inc  = {1'b0, sec_v} + (CountBits+1)'(1);
  assign grow_ok  = size_q < mx;
  assign prod     = {{SizeBits{1'b0}}, quot} * {{CountBits{1'b0}}, size_q};
  assign low_load = ProdBits'(sum_q) < prod;

  // Sequencer, pool state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      spw_q     <= SpwReset;
      maxw_q    <= MaxwReset;
      for (int i = 0; i < MaxWorkers; i++) begin
        order_q[i] <= '0;
        load_q[i]  <= '0;
      end
      size_q    <= SizeBits'(1);
      used_q    <= MaxWorkers'(1);
      mark_q    <= 1'b0;
      drain_q   <= '0;
      cmd_q     <= CMD_NEW;
      cw_q      <= '0;
      idx_q     <= '0;
      ret_v_q   <= 1'b0;
      ret_w_q   <= '0;
      min1_v_q  <= '0;
      min1_p_q  <= '0;
      min1_s_q  <= '0;
      sum_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      // Drop the result once taken, unless a new one replaces it
      if (m_valid_q && m_axis_tready_i && !res_load) begin
        m_valid_q <= 1'b0;
      end

      // Register writes
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_SPW:  spw_q  <= cfg_data_i;
          CFG_MAXW: maxw_q <= cfg_data_i[MaxwBits-1:0];
          default:  ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            cmd_q   <= in_cmd;
            cw_q    <= s_axis_tdata_i[SlotBits-1:0];
            idx_q   <= '0;
            ret_v_q <= 1'b0;
            ret_w_q <= '0;
            if (in_cmd == CMD_CLOSE || in_cmd == CMD_NOP) begin
              state_q <= ST_CLOSE;
            end else if (in_cmd == CMD_IDLE && mark_q && rd_data == '0) begin
              state_q <= ST_RETIRE;
            end else begin
              state_q <= ST_SCAN1;
            end
          end
        end

        ST_CLOSE: begin
          if (out_free) begin
            if (cmd_q == CMD_CLOSE && rd_data != '0) begin
              load_q[cw_q] <= rd_data - CountBits'(1);
            end
            m_valid_q <= 1'b1;
            m_data_q  <= OutDataBits'({size_q,
                                       (mark_q ? drain_q : {SlotBits{1'b0}}), mark_q,
                                       {SlotBits{1'b0}}, 1'b0,
                                       {SlotBits{1'b0}}, 1'b0,
                                       {SlotBits{1'b0}}, 1'b0});
            state_q   <= ST_IDLE;
          end
        end

        // Find the draining worker and close the gap behind it
        ST_RETIRE: begin
          if (cur_slot == drain_q) begin
            for (int j = 0; j < MaxWorkers - 1; j++) begin
              if (SlotBits'(j) >= idx_q) begin
                order_q[j] <= order_q[j+1];
              end
            end
            size_q          <= size_q - SizeBits'(1);
            used_q[drain_q] <= 1'b0;
            ret_v_q         <= 1'b1;
            ret_w_q         <= drain_q;
            mark_q          <= 1'b0;
            idx_q           <= '0;
            state_q         <= ST_SCAN1;
          end else if (idx_last) begin
            mark_q  <= 1'b0;
            idx_q   <= '0;
            state_q <= ST_SCAN1;
          end else begin
            idx_q <= idx_q + SlotBits'(1);
          end
        end

        // First pass: minimum and total load
        ST_SCAN1: begin
          if (idx_last) begin
            state_q <= ST_MID;
          end else begin
            idx_q <= idx_q + SlotBits'(1);
          end
        end

        ST_MID: begin
          min1_v_q <= sec_v;
          min1_p_q <= sec_p;
          min1_s_q <= sec_s;
          sum_q    <= scan_sum;
          idx_q    <= '0;
          state_q  <= ST_SCAN2;
        end

        // Second pass: minimum over the other workers
        ST_SCAN2: begin
          if (idx_last) begin
            state_q <= ST_DECIDE;
          end else begin
            idx_q <= idx_q + SlotBits'(1);
          end
        end

        ST_DECIDE: begin
          if (!div_busy && out_free) begin
            logic                 asg_v, add_v, mark_n;
            logic [SlotBits-1:0]  asg_w, add_w, drain_n;
            logic [SizeBits-1:0]  size_n;
            asg_v   = 1'b0;
            asg_w   = '0;
            add_v   = 1'b0;
            add_w   = '0;
            mark_n  = mark_q;
            drain_n = drain_q;
            size_n  = size_q;
            if (mark_q && size_q > SizeBits'(1)) begin
              drain_n = min1_s_q;
              if (is_new) begin
                asg_v = 1'b1;
                asg_w = sec_s;
                if (sec_v != '1) begin
                  load_q[sec_s] <= sec_v + CountBits'(1);
                end
              end
              if (sec_inc >= {1'b0, spw_q} && grow_ok) begin
                mark_n = 1'b0;
              end
            end else begin
              if (is_new) begin
                asg_v = 1'b1;
                asg_w = min1_s_q;
                if (min1_v_q != '1) begin
                  load_q[min1_s_q] <= min1_v_q + CountBits'(1);
                end
              end
              if (min_inc >= {1'b0, spw_q} && grow_ok) begin
                add_v = 1'b1;
                add_w = free_slot;
                size_n = size_q + SizeBits'(1);
                order_q[size_q[SlotBits-1:0]] <= free_slot;
                load_q[free_slot]             <= '0;
                used_q[free_slot]             <= 1'b1;
              end else if (size_q > SizeBits'(1) && low_load) begin
                mark_n  = 1'b1;
                drain_n = min1_s_q;
              end
            end
            mark_q    <= mark_n;
            drain_q   <= drain_n;
            size_q    <= size_n;
            m_valid_q <= 1'b1;
            m_data_q  <= OutDataBits'({size_n,
                                       (mark_n ? drain_n : {SlotBits{1'b0}}), mark_n,
                                       ret_w_q, ret_v_q,
                                       add_w, add_v,
                                       asg_w, asg_v});
            state_q   <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // Pool size stays within 1..MaxWorkers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (size_q != '0) && (32'(size_q) <= MaxWorkers))
    else $error("pool size out of range");

  // Occupied slots match the pool size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == 32'(size_q))
    else $error("occupied slots disagree with pool size");

  // The drain mark always names a worker in the pool
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_q |-> used_q[drain_q])
    else $error("drain mark on a slot outside the pool");

  // A reported addition leaves at least two workers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[4]) |-> (m_axis_tdata_o[19:16] > 4'd1))
    else $error("added worker reported with a single-worker pool");

endmodule

`default_nettype wire
